// ===== src/kse_pkg.sv =====
package kse_pkg;

    // Keyword sequence
    localparam int NUM_KEYWORDS = 5;
    localparam int KW_TABLE     = 5;
    localparam int KW_MAXLEN    = 26;
    localparam int KW_NUM_W     = 3;
    localparam int POS_W        = 5;

    localparam logic [7:0] QUOTE = 8'h22;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef enum logic [1:0] {
        MODE_MATCH,
        MODE_SEEK,
        MODE_VALUE,
        MODE_DONE
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_ALL_FOUND,
        KIND_INCOMPLETE
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
        logic       last_of_file;
    } t_in_item;

    typedef struct packed {
        t_kind      result_kind;
        logic [1:0] field_index;
        logic [7:0] value_byte;
    } t_out_item;

    // Keyword text, right aligned: character 0 sits in the highest used byte
    localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_TABLE] = '{
        "p:encryptedKey",
        "spinCount",
        "saltValue",
        "encryptedVerifierHashInput",
        "encryptedVerifierHashValue"
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_TABLE] = '{
        5'd14, 5'd9, 5'd9, 5'd26, 5'd26
    };

    // Character at position pos of keyword sel (pos below its length)
    function automatic logic [7:0] kw_char(input logic [KW_NUM_W-1:0] sel,
                                           input logic [POS_W-1:0]    pos);
        logic [POS_W-1:0] idx;
        idx = KW_LEN[sel] - 5'd1 - pos;
        return KW_TEXT[sel][{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== src/keyword_sequence_value_extractor.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------
// in       | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// One byte is taken per cycle; its results land in a 4-entry output queue on
// the same edge and are offered from the next cycle, one per cycle.
// A byte yields at most two results, so input stalls while fewer than two
// queue slots are free; sustained rate is one byte per cycle unless the
// output side stalls or bytes with two results fill the queue.
// Reset (synchronous, i_rst_n low) clears queue and scan; first_of_file restarts only the scan.
module keyword_sequence_value_extractor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  kse_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output kse_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall
);

    localparam logic [kse_pkg::KW_NUM_W-1:0] KW_LAST =
        kse_pkg::KW_NUM_W'(kse_pkg::KW_TABLE - 1);
    localparam logic [kse_pkg::KW_NUM_W:0] KW_END =
        (kse_pkg::KW_NUM_W + 1)'(kse_pkg::NUM_KEYWORDS);

    // Scan state
    kse_pkg::t_mode                  r_mode, n_mode, eff_mode;
    logic [kse_pkg::KW_NUM_W-1:0]    r_kw, n_kw, eff_kw;
    logic [kse_pkg::POS_W-1:0]       r_pos, n_pos, eff_pos;

    // Output queue
    kse_pkg::t_out_item              r_fifo [kse_pkg::FIFO_DEPTH];
    logic [kse_pkg::PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [kse_pkg::CNT_W-1:0]       r_count;

    logic                            in_accept, out_pop;
    logic [kse_pkg::KW_NUM_W-1:0]    sel;
    logic [kse_pkg::POS_W-1:0]       len, pos_c, pos_inc;
    logic                            hit, quote, all_found;
    logic                            res_vld, inc_vld;
    kse_pkg::t_out_item              res_item, inc_item;
    logic [1:0]                      n_push;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_count > kse_pkg::CNT_W'(kse_pkg::FIFO_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign out_pop     = o_out_valid && !i_out_stall;

    // Keyword compare and scan next state
    always_comb begin
        eff_mode  = i_in_data.first_of_file ? kse_pkg::MODE_MATCH : r_mode;
        eff_kw    = i_in_data.first_of_file ? '0 : r_kw;
        eff_pos   = i_in_data.first_of_file ? '0 : r_pos;
        sel       = (eff_kw > KW_LAST) ? KW_LAST : eff_kw;
        len       = kse_pkg::KW_LEN[sel];
        pos_c     = (eff_pos >= len) ? '0 : eff_pos;
        pos_inc   = pos_c + 5'd1;
        hit       = i_in_data.data_byte == kse_pkg::kw_char(sel, pos_c);
        quote     = i_in_data.data_byte == kse_pkg::QUOTE;
        all_found = ({1'b0, eff_kw} + 4'd1) >= KW_END;
        n_mode    = eff_mode;
        n_kw      = eff_kw;
        n_pos     = eff_pos;
        case (eff_mode)
            kse_pkg::MODE_MATCH: begin
                if (!hit) begin
                    n_pos = '0;
                end else if (pos_inc == len) begin
                    n_pos = '0;
                    if (eff_kw == '0) begin
                        n_kw = 3'd1;
                    end else begin
                        n_mode = kse_pkg::MODE_SEEK;
                    end
                end else begin
                    n_pos = pos_inc;
                end
            end
            kse_pkg::MODE_SEEK: begin
                if (quote) begin
                    n_mode = kse_pkg::MODE_VALUE;
                end
            end
            kse_pkg::MODE_VALUE: begin
                if (quote) begin
                    if (all_found) begin
                        n_mode = kse_pkg::MODE_DONE;
                    end else begin
                        n_kw   = eff_kw + 3'd1;
                        n_pos  = '0;
                        n_mode = kse_pkg::MODE_MATCH;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Results of the current byte
    always_comb begin
        res_vld              = eff_mode == kse_pkg::MODE_VALUE;
        res_item.field_index = 2'(eff_kw - 3'd1);
        if (!quote) begin
            res_item.result_kind = kse_pkg::KIND_BYTE;
            res_item.value_byte  = i_in_data.data_byte;
        end else begin
            res_item.result_kind = all_found ? kse_pkg::KIND_ALL_FOUND : kse_pkg::KIND_END;
            res_item.value_byte  = '0;
        end
        inc_vld              = i_in_data.last_of_file && (n_mode != kse_pkg::MODE_DONE);
        inc_item.result_kind = kse_pkg::KIND_INCOMPLETE;
        inc_item.field_index = '0;
        inc_item.value_byte  = '0;
        n_push               = in_accept ? (2'(res_vld) + 2'(inc_vld)) : 2'd0;
    end

    // Scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= kse_pkg::MODE_MATCH;
            r_kw   <= '0;
            r_pos  <= '0;
        end else if (in_accept) begin
            r_mode <= n_mode;
            r_kw   <= n_kw;
            r_pos  <= n_pos;
        end
    end

    // Queue storage; no reset on payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (res_vld) begin
                r_fifo[r_wr_ptr] <= res_item;
                if (inc_vld) begin
                    r_fifo[r_wr_ptr + 2'd1] <= inc_item;
                end
            end else if (inc_vld) begin
                r_fifo[r_wr_ptr] <= inc_item;
            end
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + n_push;
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + kse_pkg::CNT_W'(n_push) - kse_pkg::CNT_W'(out_pop);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kse_pkg::CNT_W'(kse_pkg::FIFO_DEPTH))
        else $error("output queue overfilled");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> r_count <= kse_pkg::CNT_W'(kse_pkg::FIFO_DEPTH - 2))
        else $error("byte taken without room for two results");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_pop && n_push == 2'd0) |=> r_count == $past(r_count) - 3'd1)
        else $error("fill count did not drop on pop");

    a_value_kw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == kse_pkg::MODE_SEEK || r_mode == kse_pkg::MODE_VALUE) |-> r_kw != '0)
        else $error("value phase entered on anchor keyword");

    a_done_kw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == kse_pkg::MODE_DONE |-> ({1'b0, r_kw} + 4'd1) >= KW_END)
        else $error("done before last keyword");
`endif

endmodule

// ===== tb/sv/keyword_sequence_value_extractor_test.sv =====
`timescale 1ns / 1ps

module keyword_sequence_value_extractor_test;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    kse_pkg::t_in_item  in_data = '0;
    logic               in_stall;
    logic               out_valid;
    kse_pkg::t_out_item out_data;
    logic               out_stall = 1'b0;

    keyword_sequence_value_extractor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // Scan state mirror
    logic [2:0]     kw_num;
    logic [4:0]     match_pos;
    kse_pkg::t_mode scan_state;

    kse_pkg::t_out_item pending_results[$];
    kse_pkg::t_out_item want;
    logic [7:0]         file_bytes[$];
    int                 err_count = 0;
    int                 items_sent = 0;
    bit                 idle_on = 1'b0;
    int                 hold_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic string keyword_text(input int unsigned sel);
        case (sel)
            0: return "p:encryptedKey";
            1: return "spinCount";
            2: return "saltValue";
            3: return "encryptedVerifierHashInput";
            default: return "encryptedVerifierHashValue";
        endcase
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_result(input kse_pkg::t_kind k, input logic [1:0] fld,
                                         input logic [7:0] b);
        kse_pkg::t_out_item r;
        r.result_kind = k;
        r.field_index = fld;
        r.value_byte  = b;
        pending_results.push_back(r);
    endfunction

    // Advance the scan mirror by one accepted byte, queueing its results
    function automatic void scan_byte(input kse_pkg::t_in_item it);
        string       kw;
        int unsigned pos;
        logic [2:0]  prev_kw;
        logic [1:0]  fld;
        if (it.first_of_file) begin
            kw_num     = '0;
            match_pos  = '0;
            scan_state = kse_pkg::MODE_MATCH;
        end
        prev_kw = kw_num - 3'd1;
        fld     = prev_kw[1:0];
        case (scan_state)
            kse_pkg::MODE_MATCH: begin
                kw  = keyword_text(32'(kw_num));
                pos = 32'(match_pos);
                if (pos >= kw.len()) pos = 0;
                if (it.data_byte == kw[pos]) pos++;
                else pos = 0;
                // completing byte switches state, nothing consumed for it
                if (pos == kw.len()) begin
                    pos = 0;
                    if (kw_num == 3'd0) kw_num = 3'd1;
                    else scan_state = kse_pkg::MODE_SEEK;
                end
                match_pos = pos[4:0];
            end
            kse_pkg::MODE_SEEK: begin
                if (it.data_byte == kse_pkg::QUOTE) scan_state = kse_pkg::MODE_VALUE;
            end
            kse_pkg::MODE_VALUE: begin
                if (it.data_byte != kse_pkg::QUOTE) begin
                    queue_result(kse_pkg::KIND_BYTE, fld, it.data_byte);
                end else if (int'(kw_num) + 1 >= kse_pkg::NUM_KEYWORDS) begin
                    queue_result(kse_pkg::KIND_ALL_FOUND, fld, 8'h00);
                    scan_state = kse_pkg::MODE_DONE;
                end else begin
                    queue_result(kse_pkg::KIND_END, fld, 8'h00);
                    kw_num     = kw_num + 3'd1;
                    match_pos  = '0;
                    scan_state = kse_pkg::MODE_MATCH;
                end
            end
            default: ;
        endcase
        if (it.last_of_file && scan_state != kse_pkg::MODE_DONE)
            queue_result(kse_pkg::KIND_INCOMPLETE, 2'd0, 8'h00);
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Output side stall pattern
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            hold_cnt  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d field=%0d byte=%02h",
                                          out_data.result_kind, out_data.field_index,
                                          out_data.value_byte));
            end else begin
                want = pending_results.pop_front();
                if (out_data.result_kind !== want.result_kind)
                    report_mismatch($sformatf("result_kind %0d, want %0d",
                                              out_data.result_kind, want.result_kind));
                if (out_data.field_index !== want.field_index)
                    report_mismatch($sformatf("field_index %0d, want %0d",
                                              out_data.field_index, want.field_index));
                if (out_data.value_byte !== want.value_byte)
                    report_mismatch($sformatf("value_byte %02h, want %02h",
                                              out_data.value_byte, want.value_byte));
            end
        end
    end

    // Offer one item, wait until it is taken, then predict it
    task automatic send_item(input kse_pkg::t_in_item it);
        int gap;
        gap = idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        scan_byte(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit first_b, input bit last_b);
        kse_pkg::t_in_item it;
        it.data_byte     = b;
        it.first_of_file = first_b;
        it.last_of_file  = last_b;
        send_item(it);
    endtask

    task automatic send_text(input string s, input bit first_b, input bit last_b);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], first_b && i == 0, last_b && i == s.len() - 1);
    endtask

    // Hold off the sender until every result is out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Complete file: empty value, extreme bytes, last byte closes last value
    task automatic test_full_file();
        idle_on = 1'b0;
        send_text("x p:encryptedKey spinCount=\"100000\"", 1'b1, 1'b0);
        send_text("saltValue=\"", 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_text("\"encryptedVerifierHashInput=\"\"", 1'b0, 1'b0);
        send_text("encryptedVerifierHashValue\"ab\"", 1'b0, 1'b1);
        // ignored while done, even with last set
        send_text("zz\"q\"", 1'b0, 1'b1);
        drain();
    endtask

    // Files cut short in every mode, plus scanning on past last_of_file
    task automatic test_truncated();
        idle_on = 1'b1;
        send_text("p:encr", 1'b1, 1'b1);
        send_text("p:encryptedKey spinCount =", 1'b1, 1'b1);
        send_text("p:encryptedKeyspinCount\"7", 1'b1, 1'b1);
        send_text("8\"", 1'b0, 1'b1);
        send_text("saltValue\"s\"encryptedVerifierHashInput\"", 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        drain();
    endtask

    // Naive restart: the mismatching byte is not compared again
    task automatic test_naive_mismatch();
        idle_on = 1'b1;
        send_text("pp:encryptedKey spinspinCount\"a\"", 1'b1, 1'b0);
        send_text("p:encryptedKey spinCount\"", 1'b0, 1'b0);
        send_text("spinCount\"9", 1'b1, 1'b0);
        send_text("p:encryptedKeysaltValue\"b\"", 1'b1, 1'b1);
        drain();
    endtask

    function automatic logic [7:0] noise_byte(input int unsigned sel);
        string      kw;
        logic [7:0] b;
        kw = keyword_text(sel);
        if ($urandom_range(0, 1) == 1) b = kw[$urandom_range(0, kw.len() - 1)];
        else b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == kse_pkg::QUOTE);
        return b;
    endfunction

    // Well-formed file with random content and occasional broken keywords
    function automatic void build_file();
        string       kw;
        int unsigned plen;
        logic [7:0]  b;
        file_bytes.delete();
        repeat ($urandom_range(0, 5)) file_bytes.push_back(noise_byte(0));
        for (int k = 0; k < kse_pkg::NUM_KEYWORDS; k++) begin
            kw = keyword_text(k);
            if ($urandom_range(0, 3) == 0) begin
                plen = $urandom_range(1, kw.len() - 1);
                for (int i = 0; i < plen; i++) file_bytes.push_back(kw[i]);
                do b = noise_byte(k); while (b == kw[plen]);
                file_bytes.push_back(b);
            end
            for (int i = 0; i < kw.len(); i++) file_bytes.push_back(kw[i]);
            if (k > 0) begin
                repeat ($urandom_range(0, 3)) file_bytes.push_back(plain_byte());
                file_bytes.push_back(kse_pkg::QUOTE);
                repeat ($urandom_range(0, 6)) file_bytes.push_back(plain_byte());
                file_bytes.push_back(kse_pkg::QUOTE);
            end
            if (k + 1 < kse_pkg::NUM_KEYWORDS)
                repeat ($urandom_range(0, 3)) file_bytes.push_back(noise_byte(k + 1));
        end
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_random_files();
        int stop_at;
        bit with_first;
        while (items_sent < 1300) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                // raw noise with stray flags
                repeat ($urandom_range(5, 30))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
            end else begin
                build_file();
                with_first = ($urandom_range(0, 9) != 0);
                stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, file_bytes.size() - 1)
                                                      : file_bytes.size() - 1;
                for (int i = 0; i <= stop_at; i++) begin
                    if ($urandom_range(0, 199) == 0) drain();
                    send_byte(file_bytes[i], with_first && i == 0, i == stop_at);
                end
            end
        end
        drain();
    endtask

    initial begin
        kw_num     = '0;
        match_pos  = '0;
        scan_state = kse_pkg::MODE_MATCH;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_full_file();
        test_truncated();
        test_naive_mismatch();
        test_random_files();
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
